// ===== rtl/lci_pkg.sv =====
// shared constants for the line/circle intersection pipeline
`default_nettype none
package lci_pkg;

    // divider: 94-bit dividend, 59-bit divisor, quotient saturated at 2^40
    localparam int NUM_W     = 94;
    localparam int DEN_W     = 59;
    localparam int QUO_W     = 41;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam logic [QUO_W-1:0] QUO_SAT = QUO_W'(1) << (QUO_W - 1);

    // square root: 122-bit radicand, one root bit per stage
    localparam int SQ_STEPS = 61;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int REM_W    = 64;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_VERT = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/lci_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating
`default_nettype none
module lci_div_pipe (
    input  logic                          clk,
    input  logic                          en,
    input  logic [lci_pkg::NUM_W-1:0]     num,
    input  logic [lci_pkg::DEN_W-1:0]     den,
    output logic [lci_pkg::QUO_W-1:0]     quo
);

    typedef struct packed {
        logic                      ovf;
        logic [lci_pkg::DEN_W-1:0] rem;
        logic [lci_pkg::QUO_W-1:0] low;
        logic [lci_pkg::QUO_W-1:0] q;
        logic [lci_pkg::DEN_W-1:0] den;
    } dstage_t;

    dstage_t st_reg [0:lci_pkg::DIV_STEPS];
    dstage_t st0_next;
    logic [lci_pkg::NUM_W-lci_pkg::QUO_W-1:0] num_hi;

    // quotient too big for the low bits means saturation anyway
    always_comb
    begin
        num_hi       = num[lci_pkg::NUM_W-1:lci_pkg::QUO_W];
        st0_next.ovf = lci_pkg::DEN_W'(num_hi) >= den;
        st0_next.rem = st0_next.ovf ? '0 : lci_pkg::DEN_W'(num_hi);
        st0_next.low = num[lci_pkg::QUO_W-1:0];
        st0_next.q   = '0;
        st0_next.den = den;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar gi = 0; gi < lci_pkg::DIV_STEPS; gi++)
    begin : g_step
        logic [lci_pkg::DEN_W:0] cur;
        logic [lci_pkg::DEN_W:0] dext;
        logic                    take;
        dstage_t                 st_next;

        always_comb
        begin
            cur          = {st_reg[gi].rem, st_reg[gi].low[lci_pkg::QUO_W-1]};
            dext         = {1'b0, st_reg[gi].den};
            take         = cur >= dext;
            st_next.ovf  = st_reg[gi].ovf;
            st_next.den  = st_reg[gi].den;
            st_next.low  = st_reg[gi].low << 1;
            st_next.q    = {st_reg[gi].q[lci_pkg::QUO_W-2:0], take};
            st_next.rem  = take ? lci_pkg::DEN_W'(cur - dext) : lci_pkg::DEN_W'(cur);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[gi+1] <= st_next;
            end
        end
    end

    assign quo = (st_reg[lci_pkg::DIV_STEPS].ovf ||
                  st_reg[lci_pkg::DIV_STEPS].q > lci_pkg::QUO_SAT)
                 ? lci_pkg::QUO_SAT : st_reg[lci_pkg::DIV_STEPS].q;

endmodule
`default_nettype wire

// ===== rtl/line_circle_intersection_core.sv =====
// throughput: one request per cycle while the output queue is not full, set by the fully pipelined root and dividers
// the root takes 61 stages (one bit each), each divider 42 stages
// a two-entry output queue holds results; in_ready drops only when it is full
// reset clears all valid bits and the queue; no data registers are reset
`default_nettype none
module line_circle_intersection_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] line_start_x,
    input  logic signed [31:0] line_start_y,
    input  logic signed [31:0] line_end_x,
    input  logic signed [31:0] line_end_y,
    input  logic signed [31:0] circle_center_x,
    input  logic signed [31:0] circle_center_y,
    input  logic [30:0]        circle_radius,
    input  logic signed [31:0] particle_x,
    input  logic signed [31:0] particle_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] hit_x,
    output logic signed [31:0] hit_y,
    output logic [1:0]         status
);

    typedef struct packed {
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [29:0] sdx;
        logic signed [29:0] sdy;
    } geo_t;

    typedef struct packed {
        geo_t               g;
        logic signed [32:0] u;
        logic signed [32:0] v;
        logic [28:0]        adx;
        logic [28:0]        ady;
        logic [30:0]        r;
        logic               vert;
    } sa_t;

    typedef struct packed {
        geo_t               g;
        logic signed [62:0] pu;
        logic signed [62:0] pv;
        logic signed [62:0] qa;
        logic signed [62:0] qb;
        logic [57:0]        aa;
        logic [57:0]        bb;
        logic [61:0]        rr;
        logic               vert;
    } sb_t;

    typedef struct packed {
        geo_t               g;
        logic signed [63:0] p;
        logic signed [63:0] q;
        logic [58:0]        den;
        logic [61:0]        rr;
        logic               vert;
    } sc_t;

    typedef struct packed {
        geo_t               g;
        logic signed [63:0] p;
        logic [62:0]        qm;
        logic [58:0]        den;
        logic [61:0]        rr;
        logic               vert;
    } sd_t;

    typedef struct packed {
        geo_t               g;
        logic signed [63:0] p;
        logic [58:0]        den;
        logic [63:0]        ll;
        logic [58:0]        lh;
        logic [61:0]        hl;
        logic [56:0]        hh;
        logic [63:0]        qll;
        logic [62:0]        qlh;
        logic [61:0]        qhh;
        logic               vert;
    } se_t;

    typedef struct packed {
        geo_t               g;
        logic signed [63:0] p;
        logic [58:0]        den;
        logic [120:0]       rd;
        logic [125:0]       qq;
        logic               vert;
    } sf_t;

    typedef struct packed {
        geo_t               g;
        logic signed [63:0] p;
        logic [58:0]        den;
        logic [1:0]         st;
    } side_t;

    typedef struct packed {
        logic [lci_pkg::REM_W-1:0]    rem;
        logic [lci_pkg::SQ_STEPS-1:0] root;
        logic [lci_pkg::RAD_W-1:0]    rad;
    } sq_t;

    typedef struct packed {
        geo_t               g;
        logic [58:0]        den;
        logic [1:0]         st;
        logic signed [64:0] t1;
        logic signed [64:0] t2;
    } sh_t;

    typedef struct packed {
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [3:0]         neg;
        logic [1:0]         st;
    } tail_t;

    typedef struct packed {
        tail_t       tl;
        logic [58:0] den;
        logic [28:0] mx;
        logic [28:0] my;
        logic [63:0] m1;
        logic [63:0] m2;
    } si_t;

    typedef struct packed {
        tail_t            tl;
        logic [58:0]      den;
        logic [3:0][60:0] lo;
        logic [3:0][60:0] hi;
    } sj_t;

    typedef struct packed {
        logic signed [42:0] x1;
        logic signed [42:0] y1;
        logic signed [42:0] x2;
        logic signed [42:0] y2;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [1:0]         st;
    } sl_t;

    typedef struct packed {
        logic signed [42:0] x1;
        logic signed [42:0] y1;
        logic signed [42:0] x2;
        logic signed [42:0] y2;
        logic signed [43:0] ex1;
        logic signed [43:0] ey1;
        logic signed [43:0] ex2;
        logic signed [43:0] ey2;
        logic [1:0]         st;
    } sn_t;

    typedef struct packed {
        logic signed [42:0] x1;
        logic signed [42:0] y1;
        logic signed [42:0] x2;
        logic signed [42:0] y2;
        logic [3:0][42:0]   m;
        logic [1:0]         st;
    } so_t;

    typedef struct packed {
        logic signed [42:0] x1;
        logic signed [42:0] y1;
        logic signed [42:0] x2;
        logic signed [42:0] y2;
        logic [3:0][41:0]   hh;
        logic [3:0][42:0]   hl;
        logic [3:0][43:0]   ll;
        logic [1:0]         st;
    } sp_t;

    typedef struct packed {
        logic signed [42:0] x1;
        logic signed [42:0] y1;
        logic signed [42:0] x2;
        logic signed [42:0] y2;
        logic [86:0]        d1;
        logic [86:0]        d2;
        logic [1:0]         st;
    } sqd_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [1:0]         st;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] r;
        begin
            if (v > 43'sd2147483647)
            begin
                r = 32'sh7fffffff;
            end
            else if (v < -43'sd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = 32'(v);
            end
            return r;
        end
    endfunction

    logic en;

    // ---------------- stage a: direction and reduction ----------------
    logic signed [32:0] dx, dy;
    logic [32:0]        adx_full, ady_full, amax;
    logic [2:0]         sh;
    logic [28:0]        adx_s, ady_s;
    sa_t a_next, a_reg;
    logic a_vld_reg;

    always_comb
    begin
        dx       = 33'(line_end_x) - 33'(line_start_x);
        dy       = 33'(line_end_y) - 33'(line_start_y);
        adx_full = dx[32] ? 33'(-dx) : 33'(dx);
        ady_full = dy[32] ? 33'(-dy) : 33'(dy);
        amax     = adx_full | ady_full;
        if (amax[32])
        begin
            sh = 3'd4;
        end
        else if (amax[31])
        begin
            sh = 3'd3;
        end
        else if (amax[30])
        begin
            sh = 3'd2;
        end
        else if (amax[29])
        begin
            sh = 3'd1;
        end
        else
        begin
            sh = 3'd0;
        end
        adx_s        = 29'(adx_full >> sh);
        ady_s        = 29'(ady_full >> sh);
        a_next.g.xs  = line_start_x;
        a_next.g.ys  = line_start_y;
        a_next.g.px  = particle_x;
        a_next.g.py  = particle_y;
        a_next.g.sdx = dx[32] ? -signed'({1'b0, adx_s}) : signed'({1'b0, adx_s});
        a_next.g.sdy = dy[32] ? -signed'({1'b0, ady_s}) : signed'({1'b0, ady_s});
        a_next.u     = 33'(circle_center_x) - 33'(line_start_x);
        a_next.v     = 33'(circle_center_y) - 33'(line_start_y);
        a_next.adx   = adx_s;
        a_next.ady   = ady_s;
        a_next.r     = circle_radius;
        a_next.vert  = (dx == 33'sd0);
    end

    // ---------------- stage b: products ----------------
    sb_t b_next, b_reg;
    logic b_vld_reg;

    always_comb
    begin
        b_next.g    = a_reg.g;
        b_next.pu   = 63'(a_reg.u) * 63'(a_reg.g.sdx);
        b_next.pv   = 63'(a_reg.v) * 63'(a_reg.g.sdy);
        b_next.qa   = 63'(a_reg.v) * 63'(a_reg.g.sdx);
        b_next.qb   = 63'(a_reg.u) * 63'(a_reg.g.sdy);
        b_next.aa   = 58'(a_reg.adx) * 58'(a_reg.adx);
        b_next.bb   = 58'(a_reg.ady) * 58'(a_reg.ady);
        b_next.rr   = 62'(a_reg.r) * 62'(a_reg.r);
        b_next.vert = a_reg.vert;
    end

    // ---------------- stage c: dot, cross, |d|^2 ----------------
    sc_t c_next, c_reg;
    logic c_vld_reg;

    always_comb
    begin
        c_next.g    = b_reg.g;
        c_next.p    = 64'(b_reg.pu) + 64'(b_reg.pv);
        c_next.q    = 64'(b_reg.qa) - 64'(b_reg.qb);
        c_next.den  = 59'(b_reg.aa) + 59'(b_reg.bb);
        c_next.rr   = b_reg.rr;
        c_next.vert = b_reg.vert;
    end

    // ---------------- stage d: |q| ----------------
    sd_t d_next, d_reg;
    logic d_vld_reg;

    always_comb
    begin
        d_next.g    = c_reg.g;
        d_next.p    = c_reg.p;
        d_next.qm   = 63'(c_reg.q[63] ? -c_reg.q : c_reg.q);
        d_next.den  = c_reg.den;
        d_next.rr   = c_reg.rr;
        d_next.vert = c_reg.vert;
    end

    // ---------------- stage e: partial products of r^2*D and q^2 ----------------
    se_t e_next, e_reg;
    logic e_vld_reg;

    always_comb
    begin
        e_next.g    = d_reg.g;
        e_next.p    = d_reg.p;
        e_next.den  = d_reg.den;
        e_next.ll   = 64'(d_reg.rr[31:0]) * 64'(d_reg.den[31:0]);
        e_next.lh   = 59'(d_reg.rr[31:0]) * 59'(d_reg.den[58:32]);
        e_next.hl   = 62'(d_reg.rr[61:32]) * 62'(d_reg.den[31:0]);
        e_next.hh   = 57'(d_reg.rr[61:32]) * 57'(d_reg.den[58:32]);
        e_next.qll  = 64'(d_reg.qm[31:0]) * 64'(d_reg.qm[31:0]);
        e_next.qlh  = 63'(d_reg.qm[31:0]) * 63'(d_reg.qm[62:32]);
        e_next.qhh  = 62'(d_reg.qm[62:32]) * 62'(d_reg.qm[62:32]);
        e_next.vert = d_reg.vert;
    end

    // ---------------- stage f: sum partials ----------------
    sf_t f_next, f_reg;
    logic f_vld_reg;

    always_comb
    begin
        f_next.g    = e_reg.g;
        f_next.p    = e_reg.p;
        f_next.den  = e_reg.den;
        f_next.rd   = (121'(e_reg.hh) << 64) + (121'(e_reg.lh) << 32)
                    + (121'(e_reg.hl) << 32) + 121'(e_reg.ll);
        f_next.qq   = (126'(e_reg.qhh) << 64) + (126'(e_reg.qlh) << 33)
                    + 126'(e_reg.qll);
        f_next.vert = e_reg.vert;
    end

    // ---------------- stage g: discriminant ----------------
    sq_t   sq_reg [0:lci_pkg::SQ_STEPS];
    side_t sd_reg [0:lci_pkg::SQ_STEPS];
    logic  sv_reg [0:lci_pkg::SQ_STEPS];
    sq_t   sq0_next;
    side_t sd0_next;
    logic  miss;
    logic [120:0] disc;

    always_comb
    begin
        miss          = 126'(f_reg.rd) < f_reg.qq;
        disc          = f_reg.rd - 121'(f_reg.qq);
        sq0_next.rem  = '0;
        sq0_next.root = '0;
        sq0_next.rad  = miss ? '0 : lci_pkg::RAD_W'(disc);
        sd0_next.g    = f_reg.g;
        sd0_next.p    = f_reg.p;
        sd0_next.den  = f_reg.den;
        if (f_reg.vert)
        begin
            sd0_next.st = lci_pkg::ST_VERT;
        end
        else if (miss)
        begin
            sd0_next.st = lci_pkg::ST_MISS;
        end
        else
        begin
            sd0_next.st = lci_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            e_reg     <= e_next;
            f_reg     <= f_next;
            sq_reg[0] <= sq0_next;
            sd_reg[0] <= sd0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            sv_reg[0] <= f_vld_reg;
        end
    end

    // ---------------- square root, one bit per stage ----------------
    for (genvar gi = 0; gi < lci_pkg::SQ_STEPS; gi++)
    begin : g_sqrt
        logic [lci_pkg::REM_W+1:0] cur;
        logic [lci_pkg::REM_W+1:0] trial;
        sq_t                       sq_next;

        always_comb
        begin
            cur          = {sq_reg[gi].rem, sq_reg[gi].rad[lci_pkg::RAD_W-1 -: 2]};
            trial        = (lci_pkg::REM_W+2)'({sq_reg[gi].root, 2'b01});
            sq_next.rad  = sq_reg[gi].rad << 2;
            if (cur >= trial)
            begin
                sq_next.rem  = lci_pkg::REM_W'(cur - trial);
                sq_next.root = {sq_reg[gi].root[lci_pkg::SQ_STEPS-2:0], 1'b1};
            end
            else
            begin
                sq_next.rem  = lci_pkg::REM_W'(cur);
                sq_next.root = {sq_reg[gi].root[lci_pkg::SQ_STEPS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[gi+1] <= sq_next;
                sd_reg[gi+1] <= sd_reg[gi];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[gi+1] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[gi+1] <= sv_reg[gi];
            end
        end
    end

    // ---------------- stage h: p +/- s ----------------
    sh_t h_next, h_reg;
    logic h_vld_reg;
    side_t sde;

    always_comb
    begin
        sde        = sd_reg[lci_pkg::SQ_STEPS];
        h_next.g   = sde.g;
        h_next.den = sde.den;
        h_next.st  = sde.st;
        h_next.t1  = 65'(sde.p) + signed'(65'(sq_reg[lci_pkg::SQ_STEPS].root));
        h_next.t2  = 65'(sde.p) - signed'(65'(sq_reg[lci_pkg::SQ_STEPS].root));
    end

    // ---------------- stage i: magnitudes and result signs ----------------
    si_t i_next, i_reg;
    logic i_vld_reg;

    always_comb
    begin
        i_next.tl.xs  = h_reg.g.xs;
        i_next.tl.ys  = h_reg.g.ys;
        i_next.tl.px  = h_reg.g.px;
        i_next.tl.py  = h_reg.g.py;
        i_next.tl.st  = h_reg.st;
        i_next.tl.neg = {h_reg.g.sdy[29] ^ h_reg.t2[64], h_reg.g.sdx[29] ^ h_reg.t2[64],
                         h_reg.g.sdy[29] ^ h_reg.t1[64], h_reg.g.sdx[29] ^ h_reg.t1[64]};
        i_next.den    = h_reg.den;
        i_next.mx     = 29'(h_reg.g.sdx[29] ? -h_reg.g.sdx : h_reg.g.sdx);
        i_next.my     = 29'(h_reg.g.sdy[29] ? -h_reg.g.sdy : h_reg.g.sdy);
        i_next.m1     = 64'(h_reg.t1[64] ? -h_reg.t1 : h_reg.t1);
        i_next.m2     = 64'(h_reg.t2[64] ? -h_reg.t2 : h_reg.t2);
    end

    // ---------------- stage j: numerator partial products ----------------
    sj_t j_next, j_reg;
    logic j_vld_reg;
    logic [3:0][28:0] mv;
    logic [3:0][63:0] tv;

    always_comb
    begin
        mv         = {i_reg.my, i_reg.mx, i_reg.my, i_reg.mx};
        tv         = {i_reg.m2, i_reg.m2, i_reg.m1, i_reg.m1};
        j_next.tl  = i_reg.tl;
        j_next.den = i_reg.den;
        for (int k = 0; k < 4; k++)
        begin
            j_next.lo[k] = 61'(mv[k]) * 61'(tv[k][31:0]);
            j_next.hi[k] = 61'(mv[k]) * 61'(tv[k][63:32]);
        end
    end

    // ---------------- stage k: numerators with rounding half ----------------
    logic [3:0][lci_pkg::NUM_W-1:0] k_num_next, k_num_reg;
    logic [lci_pkg::DEN_W-1:0] k_den_reg;

    // stage k side data enters the divider delay line as its first entry
    tail_t tl_reg [0:lci_pkg::DIV_LAT];
    logic  tv_reg [0:lci_pkg::DIV_LAT];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            k_num_next[k] = (lci_pkg::NUM_W'(j_reg.hi[k]) << 32)
                          + lci_pkg::NUM_W'(j_reg.lo[k])
                          + lci_pkg::NUM_W'(j_reg.den >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg     <= h_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_num_reg <= k_num_next;
            k_den_reg <= j_reg.den;
            tl_reg[0] <= j_reg.tl;
        end
    end

    // ---------------- dividers and matching delay line ----------------
    logic [3:0][lci_pkg::QUO_W-1:0] quo;

    for (genvar gk = 0; gk < 4; gk++)
    begin : g_div
        lci_div_pipe u_div (
            .clk (clk),
            .en  (en),
            .num (k_num_reg[gk]),
            .den (k_den_reg),
            .quo (quo[gk])
        );
    end

    for (genvar gd = 0; gd < lci_pkg::DIV_LAT; gd++)
    begin : g_tail
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tl_reg[gd+1] <= tl_reg[gd];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tv_reg[gd+1] <= 1'b0;
            end
            else if (en)
            begin
                tv_reg[gd+1] <= tv_reg[gd];
            end
        end
    end

    // ---------------- stage l: crossing points ----------------
    sl_t l_next, l_reg;
    logic l_vld_reg;
    tail_t tle;
    logic signed [3:0][42:0] pts;
    logic signed [42:0] base, qs;

    always_comb
    begin
        tle = tl_reg[lci_pkg::DIV_LAT];
        pts = '0;
        for (int k = 0; k < 4; k++)
        begin
            base   = (k == 0 || k == 2) ? 43'(tle.xs) : 43'(tle.ys);
            qs     = signed'(43'(quo[k]));
            pts[k] = tle.neg[k] ? base - qs : base + qs;
        end
        l_next.x1 = signed'(pts[0]);
        l_next.y1 = signed'(pts[1]);
        l_next.x2 = signed'(pts[2]);
        l_next.y2 = signed'(pts[3]);
        l_next.px = tle.px;
        l_next.py = tle.py;
        l_next.st = tle.st;
    end

    // ---------------- stage m: order by x ----------------
    sl_t m_next, m_reg;
    logic m_vld_reg;

    always_comb
    begin
        m_next = l_reg;
        if (l_reg.x1 < l_reg.x2)
        begin
            m_next.x1 = l_reg.x2;
            m_next.y1 = l_reg.y2;
            m_next.x2 = l_reg.x1;
            m_next.y2 = l_reg.y1;
        end
    end

    // ---------------- stage n: offsets to particle ----------------
    sn_t n_next, n_reg;
    logic n_vld_reg;

    always_comb
    begin
        n_next.x1  = m_reg.x1;
        n_next.y1  = m_reg.y1;
        n_next.x2  = m_reg.x2;
        n_next.y2  = m_reg.y2;
        n_next.ex1 = 44'(m_reg.x1) - 44'(m_reg.px);
        n_next.ey1 = 44'(m_reg.y1) - 44'(m_reg.py);
        n_next.ex2 = 44'(m_reg.x2) - 44'(m_reg.px);
        n_next.ey2 = 44'(m_reg.y2) - 44'(m_reg.py);
        n_next.st  = m_reg.st;
    end

    // ---------------- stage o: magnitudes ----------------
    so_t o_next, o_reg;
    logic o_vld_reg;

    always_comb
    begin
        o_next.x1   = n_reg.x1;
        o_next.y1   = n_reg.y1;
        o_next.x2   = n_reg.x2;
        o_next.y2   = n_reg.y2;
        o_next.st   = n_reg.st;
        o_next.m[0] = 43'(n_reg.ex1[43] ? -n_reg.ex1 : n_reg.ex1);
        o_next.m[1] = 43'(n_reg.ey1[43] ? -n_reg.ey1 : n_reg.ey1);
        o_next.m[2] = 43'(n_reg.ex2[43] ? -n_reg.ex2 : n_reg.ex2);
        o_next.m[3] = 43'(n_reg.ey2[43] ? -n_reg.ey2 : n_reg.ey2);
    end

    // ---------------- stage p: square partials ----------------
    sp_t p_next, p_reg;
    logic p_vld_reg;

    always_comb
    begin
        p_next.x1 = o_reg.x1;
        p_next.y1 = o_reg.y1;
        p_next.x2 = o_reg.x2;
        p_next.y2 = o_reg.y2;
        p_next.st = o_reg.st;
        for (int k = 0; k < 4; k++)
        begin
            p_next.hh[k] = 42'(o_reg.m[k][42:22]) * 42'(o_reg.m[k][42:22]);
            p_next.hl[k] = 43'(o_reg.m[k][42:22]) * 43'(o_reg.m[k][21:0]);
            p_next.ll[k] = 44'(o_reg.m[k][21:0]) * 44'(o_reg.m[k][21:0]);
        end
    end

    // ---------------- stage q: squared distances ----------------
    sqd_t q_next, q_reg;
    logic q_vld_reg;
    logic [3:0][86:0] sqv;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sqv[k] = (87'(p_reg.hh[k]) << 44) + (87'(p_reg.hl[k]) << 23)
                   + 87'(p_reg.ll[k]);
        end
        q_next.x1 = p_reg.x1;
        q_next.y1 = p_reg.y1;
        q_next.x2 = p_reg.x2;
        q_next.y2 = p_reg.y2;
        q_next.st = p_reg.st;
        q_next.d1 = sqv[0] + sqv[1];
        q_next.d2 = sqv[2] + sqv[3];
    end

    // ---------------- stage r: pick and saturate ----------------
    res_t r_next, r_reg;
    logic r_vld_reg;

    always_comb
    begin
        r_next.st = q_reg.st;
        if (q_reg.st != lci_pkg::ST_OK)
        begin
            r_next.x = '0;
            r_next.y = '0;
        end
        else if (q_reg.d1 < q_reg.d2)
        begin
            r_next.x = sat32(q_reg.x1);
            r_next.y = sat32(q_reg.y1);
        end
        else
        begin
            r_next.x = sat32(q_reg.x2);
            r_next.y = sat32(q_reg.y2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg <= l_next;
            m_reg <= m_next;
            n_reg <= n_next;
            o_reg <= o_next;
            p_reg <= p_next;
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            tv_reg[0] <= 1'b0;
            l_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            h_vld_reg <= sv_reg[lci_pkg::SQ_STEPS];
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
            tv_reg[0] <= j_vld_reg;
            l_vld_reg <= tv_reg[lci_pkg::DIV_LAT];
            m_vld_reg <= l_vld_reg;
            n_vld_reg <= m_vld_reg;
            o_vld_reg <= n_vld_reg;
            p_vld_reg <= o_vld_reg;
            q_vld_reg <= p_vld_reg;
            r_vld_reg <= q_vld_reg;
        end
    end

    // ---------------- output queue ----------------
    res_t fifo_reg [0:1];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    // pipeline moves only while the queue can take whatever reaches its end
    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;
    assign push     = en && r_vld_reg;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop      = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign hit_x  = fifo_reg[rd_ptr_reg].x;
    assign hit_y  = fifo_reg[rd_ptr_reg].y;
    assign status = fifo_reg[rd_ptr_reg].st;

endmodule
`default_nettype wire
